/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL modules.
// The modules that use them clock on clk and reset on arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

/* hdl/dhpr_pkg.sv */
package dhpr_pkg;

	localparam int NUM_BINS   = 255;
	localparam int CNT_W      = 21;
	localparam int PTR_W      = 9;
	localparam int WSUM_W     = 25;
	localparam int ACC_W      = 29;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [7:0] START_MAX  = 8'd250;
	localparam logic [7:0] START_RST  = 8'd150;
	localparam logic [PTR_W-1:0] START_MIN = 9'd5;
	localparam logic [15:0] LIMIT_RST = 16'd100;
	localparam logic [6:0] SPAN_RST   = 7'd50;

	// Division by 10 and by 100 as multiplication by a rounded-up reciprocal.
	localparam int RECIP_SH  = 28;
	localparam int M10_W     = 25;
	localparam int M100_W    = 22;
	localparam int PROD10_W  = CNT_W + M10_W;
	localparam int PROD100_W = CNT_W + M100_W;
	localparam logic [M10_W-1:0]  M10  = 25'd26843546;
	localparam logic [M100_W-1:0] M100 = 22'd2684355;

	typedef struct packed {
		logic [7:0] pixel;
		logic       last_pixel;
	} dhpr_in_t;

	typedef struct packed {
		logic [7:0] peak_bin;
		logic [7:0] lower_diff;
		logic [6:0] upper_diff;
		logic       found;
		logic       second_found;
	} dhpr_out_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START = 2'd0,
		CFG_LIMIT = 2'd1,
		CFG_SPAN  = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		P_HOLD   = 3'd0,
		P_DEC    = 3'd1,
		P_INC    = 3'd2,
		P_PIXEL  = 3'd3,
		P_ZERO   = 3'd4,
		P_TOP    = 3'd5,
		P_WALK   = 3'd6,
		P_PEAK   = 3'd7
	} ptr_op_t;

	typedef enum logic [1:0] {
		R_NONE = 2'd0,
		R_ONE  = 2'd1,
		R_TWO  = 2'd2
	} res_kind_t;

	typedef struct packed {
		ptr_op_t   ptr_op;
		logic      ptr_bstart;
		logic      rd_pixel;
		logic      in_take;
		logic      wr_inc;
		logic      wr_zero;
		logic      tot_inc;
		logic      tot_clr;
		logic      tot_load;
		logic      div_load;
		logic      win_shift;
		logic      pk_take;
		logic      min_upd;
		logic      acc_clr;
		logic      acc_add;
		logic      cnt_inc;
		logic      lo_inc;
		logic      bpre_load;
		logic      bpre_dec;
		logic      bflag_shift;
		logic      res_load;
		res_kind_t res_kind;
	} dhpr_cmd_t;

	typedef struct packed {
		logic last;
		logic ptr_zero;
		logic is_pk;
		logic ic_le_start;
		logic ic_is_min;
		logic skip_end;
		logic wsum_gt;
		logic span_done;
		logic below70;
		logic lo_lt_peak;
		logic bhit;
		logic bpre_zero;
		logic bpre_one;
		logic out_free;
	} dhpr_sts_t;

endpackage

/* hdl/dhpr_dp.sv */
`include "assert_macros.svh"

module dhpr_dp import dhpr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dhpr_cmd_t             cmd,
	output dhpr_sts_t             sts,
	input  dhpr_in_t              in_data,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output dhpr_out_t             out_data
);

	logic [7:0] start_q;
	logic [15:0] lim_q;
	logic [6:0] span_q;
	logic [7:0] start_eff;

	logic [PTR_W-1:0] ptr_q, raddr, ic;
	logic [CNT_W-1:0] bin_mem [0:NUM_BINS-1];
	logic [CNT_W-1:0] rdata_q, v, v_inc;
	logic rd_oob_q;

	logic [CNT_W-1:0] pix_cnt_q, total_q;
	logic last_q;
	logic [PROD10_W-1:0] prod10_q;
	logic [PROD100_W-1:0] prod100_q;
	logic [PROD10_W-RECIP_SH-1:0] thr10;
	logic [PROD100_W-RECIP_SH-1:0] thr100;

	logic [CNT_W-1:0] win_q [0:8];
	logic [WSUM_W-1:0] wsum_q;
	logic [7:0] peak_q, m_q, lo_q;
	logic [CNT_W-1:0] peakc_q, best_q, c;

	logic [ACC_W-1:0] acc_q;
	logic [6:0] cnt_q;
	logic [ACC_W+3:0] acc10, tot7;
	logic f1_q, f2_q, newf;
	logic [1:0] bpre_q;
	logic [PTR_W-1:0] lo_two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RST;
			lim_q <= LIMIT_RST;
			span_q <= SPAN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_START: start_q <= cfg_data[7:0];
				CFG_LIMIT: lim_q <= cfg_data[15:0];
				CFG_SPAN: span_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign start_eff = (start_q > START_MAX) ? START_MAX : start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= PTR_W'(NUM_BINS - 1);
		end else if (cmd.ptr_bstart) begin
			ptr_q <= {1'b0, peak_q} - {1'b0, lo_q} + 9'd1;
		end else begin
			case (cmd.ptr_op)
				P_HOLD: ;
				P_DEC: ptr_q <= ptr_q - 9'd1;
				P_INC: ptr_q <= ptr_q + 9'd1;
				P_PIXEL: ptr_q <= {1'b0, in_data.pixel};
				P_ZERO: ptr_q <= '0;
				P_TOP: ptr_q <= PTR_W'(NUM_BINS - 1);
				P_WALK: ptr_q <= {1'b0, start_eff} + 9'd8;
				P_PEAK: ptr_q <= {1'b0, peak_q};
				default: ;
			endcase
		end
	end

	assign raddr = cmd.rd_pixel ? {1'b0, in_data.pixel} : ptr_q;
	assign v = rd_oob_q ? '0 : rdata_q;
	assign v_inc = (v == COUNT_MAX) ? v : v + 1'b1;

	// Bins above 254 read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_oob_q <= 1'b1;
		end else begin
			rd_oob_q <= (raddr >= PTR_W'(NUM_BINS));
		end
	end

	always_ff @(posedge clk) begin
		if (raddr < PTR_W'(NUM_BINS)) begin
			rdata_q <= bin_mem[raddr[7:0]];
		end
		if (cmd.wr_zero) begin
			bin_mem[ptr_q[7:0]] <= '0;
		end else if (cmd.wr_inc && !rd_oob_q) begin
			bin_mem[ptr_q[7:0]] <= v_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_cnt_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (cmd.tot_clr) begin
				pix_cnt_q <= '0;
			end else if (cmd.tot_inc && pix_cnt_q != COUNT_MAX) begin
				pix_cnt_q <= pix_cnt_q + 1'b1;
			end
			if (cmd.in_take) begin
				last_q <= in_data.last_pixel;
			end
		end
	end

	assign thr10 = prod10_q[PROD10_W-1:RECIP_SH];
	assign thr100 = prod100_q[PROD100_W-1:RECIP_SH];
	assign ic = ptr_q + 9'd5;
	assign c = win_q[4];

	always_ff @(posedge clk) begin
		if (cmd.tot_load) begin
			total_q <= pix_cnt_q - v;
		end
		if (cmd.div_load) begin
			prod10_q <= PROD10_W'(total_q) * PROD10_W'(M10);
			prod100_q <= PROD100_W'(total_q) * PROD100_W'(M100);
			wsum_q <= '0;
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else if (cmd.win_shift) begin
			win_q[0] <= v;
			for (int k = 1; k < 9; k++) begin
				win_q[k] <= win_q[k-1];
			end
			wsum_q <= wsum_q + WSUM_W'(v) - WSUM_W'(win_q[8]);
		end
		if (cmd.pk_take) begin
			peakc_q <= c;
			best_q <= c;
			m_q <= '0;
		end else if (cmd.min_upd) begin
			if ((c < best_q) || (c == best_q && c < peakc_q)) begin
				best_q <= c;
				m_q <= ic[7:0];
			end
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.acc_add) begin
				acc_q <= acc_q + ACC_W'(v);
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 7'd1;
			end
		end
		if (cmd.bflag_shift) begin
			f2_q <= f1_q;
			f1_q <= newf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			lo_q <= '0;
			bpre_q <= '0;
		end else begin
			if (cmd.div_load) begin
				peak_q <= '0;
				lo_q <= '0;
			end else begin
				if (cmd.pk_take) begin
					peak_q <= ic[7:0];
				end
				if (cmd.lo_inc) begin
					lo_q <= lo_q + 8'd1;
				end
			end
			if (cmd.bpre_load) begin
				bpre_q <= 2'd2;
			end else if (cmd.bpre_dec) begin
				bpre_q <= bpre_q - 2'd1;
			end
		end
	end

	assign acc10 = (ACC_W+4)'({acc_q, 3'b000}) + (ACC_W+4)'({acc_q, 1'b0});
	assign tot7 = (ACC_W+4)'({total_q, 3'b000}) - (ACC_W+4)'(total_q);
	assign newf = v < CNT_W'(lim_q);
	assign lo_two = {1'b0, peak_q} - {1'b0, m_q} + 9'd3;

	always_comb begin
		sts.last = last_q;
		sts.ptr_zero = (ptr_q == '0);
		sts.is_pk = (c > win_q[3]) && (c > win_q[5]) && (c >= CNT_W'(thr100))
			&& (wsum_q > WSUM_W'(thr10));
		sts.ic_le_start = (ic <= {1'b0, start_eff});
		sts.ic_is_min = (ic == START_MIN);
		sts.skip_end = (ic == {1'b0, peak_q} - 9'd3);
		sts.wsum_gt = (wsum_q > WSUM_W'(thr10));
		sts.span_done = (cnt_q == span_q);
		sts.below70 = (acc10 < tot7);
		sts.lo_lt_peak = (lo_q < peak_q);
		sts.bhit = newf && f1_q && f2_q;
		sts.bpre_zero = (bpre_q == 2'd0);
		sts.bpre_one = (bpre_q == 2'd1);
		sts.out_free = !out_valid || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_data.upper_diff <= span_q;
			case (cmd.res_kind)
				R_ONE: begin
					out_data.peak_bin <= peak_q;
					out_data.lower_diff <= lo_q;
					out_data.found <= 1'b1;
					out_data.second_found <= 1'b0;
				end
				R_TWO: begin
					out_data.peak_bin <= peak_q;
					out_data.lower_diff <= lo_two[7:0];
					out_data.found <= 1'b1;
					out_data.second_found <= 1'b1;
				end
				default: begin
					out_data.peak_bin <= '0;
					out_data.lower_diff <= '0;
					out_data.found <= 1'b0;
					out_data.second_found <= 1'b0;
				end
			endcase
		end
	end

	`AST_IMP(a_lo_le_peak, 1'b1, lo_q <= peak_q)
	`AST_IMP(a_wr_in_range, cmd.wr_zero || (cmd.wr_inc && !rd_oob_q), ptr_q < PTR_W'(NUM_BINS))
	`AST_NEXT(a_res_shown, cmd.res_load, out_valid)

endmodule

/* hdl/dhpr_ctrl.sv */
`include "assert_macros.svh"

module dhpr_ctrl import dhpr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dhpr_sts_t sts,
	output dhpr_cmd_t cmd
);

	typedef enum logic [17:0] {
		S_CLR  = 18'h00001,
		S_IDLE = 18'h00002,
		S_PX   = 18'h00004,
		S_T0   = 18'h00008,
		S_T1   = 18'h00010,
		S_DIV  = 18'h00020,
		S_WW   = 18'h00040,
		S_WU   = 18'h00080,
		S_UP0  = 18'h00100,
		S_UW   = 18'h00200,
		S_UU   = 18'h00400,
		S_A    = 18'h00800,
		S_AW   = 18'h01000,
		S_AU   = 18'h02000,
		S_BW   = 18'h04000,
		S_BU   = 18'h08000,
		S_BC   = 18'h10000,
		S_OUT  = 18'h20000
	} state_t;

	typedef enum logic [3:0] {
		PH_MAIN   = 4'b0001,
		PH_SKIP   = 4'b0010,
		PH_DENSE  = 4'b0100,
		PH_SECOND = 4'b1000
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	res_kind_t kind_q, kind_d;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			phase_q <= PH_MAIN;
			kind_q <= R_NONE;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			kind_q <= kind_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign take = (phase_q == PH_MAIN) && sts.ic_le_start && sts.is_pk;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		phase_d = phase_q;
		kind_d = kind_q;
		case (state_q)
			S_CLR: begin
				cmd.wr_zero = 1'b1;
				cmd.ptr_op = P_DEC;
				if (sts.ptr_zero) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.rd_pixel = 1'b1;
				if (in_valid) begin
					cmd.ptr_op = P_PIXEL;
					cmd.in_take = 1'b1;
					state_d = S_PX;
				end
			end
			S_PX: begin
				cmd.wr_inc = 1'b1;
				cmd.tot_inc = 1'b1;
				if (sts.last) begin
					cmd.ptr_op = P_ZERO;
					state_d = S_T0;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_T0: state_d = S_T1;
			S_T1: begin
				cmd.tot_load = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_load = 1'b1;
				cmd.ptr_op = P_WALK;
				phase_d = PH_MAIN;
				state_d = S_WW;
			end
			S_WW: begin
				cmd.pk_take = take;
				cmd.min_upd = (phase_q != PH_MAIN);
				case (phase_q)
					PH_MAIN: if (take) phase_d = PH_SKIP;
					PH_SKIP: if (sts.skip_end) phase_d = PH_DENSE;
					PH_DENSE: if (!sts.wsum_gt) phase_d = PH_SECOND;
					default: ;
				endcase
				if (phase_q == PH_SECOND && sts.is_pk) begin
					kind_d = R_TWO;
					state_d = S_OUT;
				end else if (sts.ic_is_min) begin
					if (phase_q == PH_MAIN && !take) begin
						kind_d = R_NONE;
						state_d = S_OUT;
					end else begin
						state_d = S_UP0;
					end
				end else begin
					state_d = S_WU;
				end
			end
			S_WU: begin
				cmd.win_shift = 1'b1;
				cmd.ptr_op = P_DEC;
				state_d = S_WW;
			end
			S_UP0: begin
				cmd.ptr_op = P_PEAK;
				cmd.acc_clr = 1'b1;
				state_d = S_UW;
			end
			S_UW: state_d = S_UU;
			S_UU: begin
				cmd.acc_add = 1'b1;
				if (sts.span_done) begin
					cmd.ptr_op = P_PEAK;
					state_d = S_A;
				end else begin
					cmd.ptr_op = P_INC;
					cmd.cnt_inc = 1'b1;
					state_d = S_UW;
				end
			end
			S_A: begin
				if (sts.below70 && sts.lo_lt_peak) begin
					cmd.lo_inc = 1'b1;
					cmd.ptr_op = P_DEC;
					state_d = S_AW;
				end else begin
					cmd.ptr_bstart = 1'b1;
					cmd.bpre_load = 1'b1;
					state_d = S_BW;
				end
			end
			S_AW: state_d = S_AU;
			S_AU: begin
				cmd.acc_add = 1'b1;
				state_d = S_A;
			end
			S_BW: state_d = S_BU;
			S_BU: begin
				cmd.bflag_shift = 1'b1;
				if (sts.bpre_zero && sts.bhit) begin
					kind_d = R_ONE;
					state_d = S_OUT;
				end else begin
					cmd.bpre_dec = !sts.bpre_zero;
					state_d = S_BC;
				end
			end
			S_BC: begin
				if (sts.bpre_one) begin
					cmd.ptr_op = P_DEC;
					state_d = S_BW;
				end else if (sts.lo_lt_peak) begin
					cmd.lo_inc = 1'b1;
					cmd.ptr_op = P_DEC;
					state_d = S_BW;
				end else begin
					kind_d = R_ONE;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = kind_q;
					cmd.ptr_op = P_TOP;
					cmd.tot_clr = 1'b1;
					phase_d = PH_MAIN;
					state_d = S_CLR;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	`AST_NEXT(a_out_to_clr, state_q == S_OUT && sts.out_free, state_q == S_CLR)
	`AST_IMP(a_phase_idle, state_q == S_IDLE || state_q == S_PX, phase_q == PH_MAIN)
	`AST_NEXT(a_px_next, state_q == S_PX, state_q == S_IDLE || state_q == S_T0)

endmodule

/* hdl/depth_histogram_peak_range_core.sv */
// Disparity histogram peak finder. Pixels arrive as requests on the input channel and are
// counted into a 255-bin histogram held in an on-chip memory (value 255 is counted in the
// frame total but not binned); for each pixel request the block reads its bin and then
// writes the incremented count back before it accepts the next pixel. On the request flagged
// last_pixel the block walks the histogram downward from search_start_bin (capped at 250)
// with a nine-bin sliding window to find the main peak and, below its dense run, an optional
// second peak; in the single-peak case it then sums upward from the peak over upper_span + 1
// bins and walks down to widen lower_diff. One result request follows per frame; a second
// peak ends the downward walk early. Each step of a walk reads one bin through the memory
// port. After the result is queued the histogram is cleared by a sweep over all 255 bins,
// during which no pixel is accepted; the same clearing pass runs after reset. Configuration
// writes are taken at any time but are meant for an idle block.
module depth_histogram_peak_range_core import dhpr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  dhpr_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output dhpr_out_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dhpr_cmd_t cmd;
	dhpr_sts_t sts;

	// Register writes are taken whenever cfg_valid is high, so the port never stalls.
	assign cfg_ready = 1'b1;

	// The controller sequences pixel counting, the peak walks and the clearing sweep.
	dhpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the histogram memory, the window, thresholds and the result register.
	dhpr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
